// ===== hw/rtl/lsc_pkg.sv =====
// Types and constants for the session cache.
// Shared by lsc_cell and lru_session_cache_top; no dependencies.
package lsc_pkg;

   localparam int ENTRIES      = 16;
   localparam int AGE_WIDTH    = 32;
   localparam int HANDLE_WIDTH = 32;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 5;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 1'd1;

   typedef struct packed {
      logic [1:0]              command;
      logic [63:0]             key_word_0;
      logic [63:0]             key_word_1;
      logic [63:0]             key_word_2;
      logic [63:0]             key_word_3;
      logic [31:0]             auth_tag;
      logic [HANDLE_WIDTH-1:0] session_handle;
      logic [15:0]             session_size;
      logic [7:0]              alpn_id;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [HANDLE_WIDTH-1:0] found_handle;
      logic [15:0]             found_size;
      logic [7:0]              found_alpn;
      logic                    release_valid;
      logic [HANDLE_WIDTH-1:0] release_handle;
      logic [15:0]             release_size;
   } rsp_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic                    live;
      logic                    hit;
      logic [IDX_W-1:0]        hit_idx;
      logic [HANDLE_WIDTH-1:0] hit_handle;
      logic [15:0]             hit_size;
      logic [7:0]              hit_alpn;
      logic                    free;
      logic                    seen;
      logic [IDX_W-1:0]        vict_idx;
      logic [AGE_WIDTH-1:0]    vict_age;
      logic [HANDLE_WIDTH-1:0] vict_handle;
      logic [15:0]             vict_size;
   } tok_type;

   // write-back broadcast to all cells
   typedef struct packed {
      logic                    en;
      logic [IDX_W-1:0]        idx;
      logic                    set_valid;
      logic                    clr_valid;
      logic                    load_key;
      logic                    load_data;
      logic                    load_age;
      logic [AGE_WIDTH-1:0]    age;
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/lsc_cell.sv =====
// One cache slot: entry storage, match and victim check on the passing token.
// Depends on lsc_pkg.
module lsc_cell import lsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic             in_use,
   input  req_type          req,
   input  tok_type          tok_in,
   output tok_type          tok_out,
   input  wr_type           wr
);

   logic                    valid_ff;
   logic [63:0]             key0_ff, key1_ff, key2_ff, key3_ff;
   logic [31:0]             auth_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [15:0]             size_ff;
   logic [7:0]              alpn_ff;
   logic [AGE_WIDTH-1:0]    age_ff;
   tok_type                 tok_ff, tok_in_next;
   logic                    match;
   logic                    sel;

   assign match = in_use && valid_ff &&
                  key0_ff == req.key_word_0 && key1_ff == req.key_word_1 &&
                  key2_ff == req.key_word_2 && key3_ff == req.key_word_3 &&
                  (req.command == CMD_REMOVE || auth_ff == req.auth_tag);

   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.hit && match) begin
         tok_in_next.hit        = 1'b1;
         tok_in_next.hit_idx    = cell_idx;
         tok_in_next.hit_handle = handle_ff;
         tok_in_next.hit_size   = size_ff;
         tok_in_next.hit_alpn   = alpn_ff;
      end
      if (in_use && !tok_in.free) begin
         if (!valid_ff) begin
            tok_in_next.free     = 1'b1;
            tok_in_next.vict_idx = cell_idx;
         end else if (!tok_in.seen || age_ff < tok_in.vict_age) begin
            tok_in_next.seen        = 1'b1;
            tok_in_next.vict_idx    = cell_idx;
            tok_in_next.vict_age    = age_ff;
            tok_in_next.vict_handle = handle_ff;
            tok_in_next.vict_size   = size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
   assign sel     = wr.en && wr.idx == cell_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else if (sel) begin
         if (wr.set_valid) valid_ff <= 1'b1;
         if (wr.clr_valid) valid_ff <= 1'b0;
         if (wr.load_age)  age_ff   <= wr.age;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && wr.load_key) begin
         key0_ff <= req.key_word_0;
         key1_ff <= req.key_word_1;
         key2_ff <= req.key_word_2;
         key3_ff <= req.key_word_3;
         auth_ff <= req.auth_tag;
         alpn_ff <= req.alpn_id;
      end
      if (sel && wr.load_data) begin
         handle_ff <= req.session_handle;
         size_ff   <= req.session_size;
      end
   end

endmodule

// ===== hw/rtl/lru_session_cache_top.sv =====
// Top level of the session cache: control, age counter, cell chain.
// Depends on lsc_pkg and lsc_cell.
//
// Usage: a request (lookup, add or remove) enters on req_valid/req_stall with
// its fields in req_data. One response per request leaves on
// rsp_valid/rsp_stall in rsp_data: lookup hit data and/or a session handle
// the owner must free. The configuration port (csr_write_en, csr_index,
// csr_data) sets cache_enable (index 0) and entries_in_use (index 1); write
// it only while no request is outstanding.
// Flow: a scan token walks the cell chain one slot per cycle, and one
// request is in work at a time: the next is accepted only once the last
// has left the finish state. The chain length sets how long a scan takes.
// Reset: all slots invalid with age 0, global age 1, caching enabled, all
// slots in use; the block is ready in the first cycle after reset.
// A stalled response holds in the output register; the next request is
// accepted and scanned meanwhile, and waits for write-back until it drains.
module lru_session_cache_top import lsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type            state_ff, state_in;
   req_type              req_ff;
   tok_type              res_ff;
   tok_type              tok_chain [ENTRIES+1];
   logic                 launch_ff;
   logic                 enable_ff;
   logic [4:0]           eiu_ff;
   logic [AGE_WIDTH-1:0] global_age_ff, global_age_in;
   logic [AGE_WIDTH-1:0] age_inc;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   wr_type               wr;
   logic                 accept;
   logic                 out_free;
   logic                 do_finish;
   logic [ENTRIES-1:0]   in_use;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (tok_chain[ENTRIES].live) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      do_finish = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         launch_ff     <= 1'b0;
         enable_ff     <= 1'b1;
         eiu_ff        <= 5'd16;
         global_age_ff <= AGE_WIDTH'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= accept;
         if (csr_write_en && csr_index == CSR_CACHE_ENABLE)   enable_ff <= csr_data[0];
         if (csr_write_en && csr_index == CSR_ENTRIES_IN_USE) eiu_ff    <= csr_data[4:0];
         if (do_finish) global_age_ff <= global_age_in;
         if (do_finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (state_ff == ST_SCAN && tok_chain[ENTRIES].live) res_ff <= tok_chain[ENTRIES];
      if (do_finish) rsp_ff <= rsp_in;
   end

   always_comb begin
      tok_chain[0]      = '0;
      tok_chain[0].live = launch_ff;
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         assign in_use[g] = (32'(g) < 32'(eiu_ff));
         lsc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(g)),
            .in_use   (in_use[g]),
            .req      (req_ff),
            .tok_in   (tok_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .wr       (wr)
         );
      end
   endgenerate

   assign age_inc = (global_age_ff == '1) ? global_age_ff : global_age_ff + 1'b1;

   // decide the response and the slot update from the finished scan
   always_comb begin
      rsp_in        = '0;
      wr            = '0;
      global_age_in = global_age_ff;
      case (req_ff.command)
         CMD_LOOKUP: begin
            if (enable_ff && res_ff.hit) begin
               global_age_in     = age_inc;
               wr.idx            = res_ff.hit_idx;
               wr.load_age       = 1'b1;
               wr.age            = age_inc;
               rsp_in.found        = 1'b1;
               rsp_in.found_handle = res_ff.hit_handle;
               rsp_in.found_size   = res_ff.hit_size;
               rsp_in.found_alpn   = res_ff.hit_alpn;
            end
         end
         CMD_ADD: begin
            if (eiu_ff == '0 || (res_ff.hit && res_ff.hit_handle == req_ff.session_handle
                                 && res_ff.hit_size == req_ff.session_size)) begin
               rsp_in.release_valid  = 1'b1;
               rsp_in.release_handle = req_ff.session_handle;
               rsp_in.release_size   = req_ff.session_size;
            end else if (res_ff.hit) begin
               rsp_in.release_valid  = 1'b1;
               rsp_in.release_handle = res_ff.hit_handle;
               rsp_in.release_size   = res_ff.hit_size;
               wr.idx       = res_ff.hit_idx;
               wr.load_data = 1'b1;
               wr.load_age  = 1'b1;
               wr.age       = global_age_ff;
            end else begin
               if (!res_ff.free) begin
                  rsp_in.release_valid  = 1'b1;
                  rsp_in.release_handle = res_ff.vict_handle;
                  rsp_in.release_size   = res_ff.vict_size;
               end
               wr.idx       = res_ff.vict_idx;
               wr.set_valid = 1'b1;
               wr.load_key  = 1'b1;
               wr.load_data = 1'b1;
               wr.load_age  = 1'b1;
               wr.age       = global_age_ff;
            end
         end
         CMD_REMOVE: begin
            if (res_ff.hit) begin
               rsp_in.release_valid  = 1'b1;
               rsp_in.release_handle = res_ff.hit_handle;
               rsp_in.release_size   = res_ff.hit_size;
               wr.idx       = res_ff.hit_idx;
               wr.clr_valid = 1'b1;
               wr.load_age  = 1'b1;
               wr.age       = '0;
            end
         end
         default: ;
      endcase
      wr.en = do_finish;
      if (!do_finish) global_age_in = global_age_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
